@@ sv/tafn_pkg.sv @@
// Shared widths, codes and controller-to-datapath command types for triangle assembly.
package tafn_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int COORD_W          = 32;
    localparam int CORNER_W         = 13;
    localparam int NORM_W           = 16;
    localparam int NORM_FRAC        = 14;
    localparam int CFG_IDX_W        = 2;
    localparam int NUM_CROSS_PROD   = 6;
    localparam int NUM_SQUARES      = 3;
    localparam int SQRT_STEPS       = 32;
    localparam int DIV_STEPS        = 15;
    localparam int CNT_W            = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_INDEX  = 2'd1,
        ST_DEGENERATE = 2'd2
    } t_status;

    // Multiplier operand pairs; the first six build the cross product.
    typedef enum logic [3:0] {
        M_D1D5 = 4'd0,
        M_D4D2 = 4'd1,
        M_D3D2 = 4'd2,
        M_D0D5 = 4'd3,
        M_D0D4 = 4'd4,
        M_D3D1 = 4'd5,
        M_SQ0  = 4'd6,
        M_SQ1  = 4'd7,
        M_SQ2  = 4'd8
    } t_mop;

    typedef struct packed {
        logic       wr_vtx;
        logic       load_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       diff;
        logic       shift;
        logic       mul_en;
        t_mop       mul_sel;
        logic       acc_en;
        t_mop       acc_sel;
        logic       cmag;
        logic       nrm_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        logic       out_load;
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic degen;
        logic norm_done;
    } t_sts;

endpackage

@@ sv/tafn_ctrl.sv @@
// Sequencing state machine for vertex storage and face normal computation.
module tafn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    input  logic          i_stall,
    input  tafn_pkg::t_sts i_sts,
    output tafn_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);
    import tafn_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_READ  = 11'b000_0000_0010,
        S_DIFF  = 11'b000_0000_0100,
        S_SHIFT = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_CMAG  = 11'b000_0010_0000,
        S_NORM  = 11'b000_0100_0000,
        S_SQ    = 11'b000_1000_0000,
        S_SQRT  = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_comp, n_comp;
    logic [1:0]       r_k, n_k;
    logic             r_ovalid, n_ovalid;
    t_cmd             cmd;

    // Vertices never wait; a face waits until the previous face is fully launched.
    assign o_stall = i_func && (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_cmd   = cmd;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_comp     = r_comp;
        n_k        = r_k;
        cmd        = '0;
        cmd.wr_vtx = i_valid && !i_func;
        cmd.comp   = r_comp;
        cmd.out_sel = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_func) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_READ;
                    n_cnt       = '0;
                end
            end
            S_READ: begin
                cmd.rd_en   = (r_cnt < CNT_W'(3));
                cmd.rd_sel  = r_cnt[1:0];
                cmd.cap_en  = (r_cnt != '0);
                cmd.cap_sel = r_cnt[1:0] - 2'd1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(3)) begin
                    n_k     = '0;
                    n_state = i_sts.bad ? S_EMIT : S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff = 1'b1;
                n_state  = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                n_cnt     = '0;
                n_state   = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en  = (r_cnt < CNT_W'(NUM_CROSS_PROD));
                cmd.mul_sel = t_mop'(r_cnt[3:0]);
                cmd.acc_en  = (r_cnt != '0);
                cmd.acc_sel = t_mop'(r_cnt[3:0] - 4'd1);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_CROSS_PROD)) begin
                    n_state = S_CMAG;
                end
            end
            S_CMAG: begin
                cmd.cmag = 1'b1;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (i_sts.degen) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else if (i_sts.norm_done) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    cmd.nrm_step = 1'b1;
                end
            end
            S_SQ: begin
                cmd.mul_en  = (r_cnt < CNT_W'(NUM_SQUARES));
                cmd.mul_sel = t_mop'(4'(M_SQ0) + r_cnt[3:0]);
                cmd.acc_en  = (r_cnt != '0);
                cmd.acc_sel = t_mop'(4'(M_SQ0) + r_cnt[3:0] - 4'd1);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_SQUARES)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.sqrt_init = (r_cnt == '0);
                cmd.sqrt_step = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS)) begin
                    n_cnt   = '0;
                    n_comp  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_init  = (r_cnt == '0);
                cmd.div_step  = (r_cnt != '0) && (r_cnt <= CNT_W'(DIV_STEPS));
                cmd.div_store = (r_cnt == CNT_W'(DIV_STEPS + 1));
                n_cnt         = r_cnt + 1'b1;
                if (cmd.div_store) begin
                    n_cnt = '0;
                    if (r_comp == 2'd2) begin
                        n_k     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_comp = r_comp + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_k          = r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_comp   <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_comp   <= n_comp;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ sv/tafn_dp.sv @@
// Datapath: vertex store, offsets, cross product, square root, division and output register.
module tafn_dp #(
    parameter int VERTEX_DEPTH = tafn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tafn_pkg::t_cmd                    i_cmd,
    output tafn_pkg::t_sts                    o_sts,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tafn_pkg::CORNER_W-1:0]     i_corner_a,
    input  logic [tafn_pkg::CORNER_W-1:0]     i_corner_b,
    input  logic [tafn_pkg::CORNER_W-1:0]     i_corner_c,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tafn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tafn_pkg::COORD_W-1:0]      i_cfg_data,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_z,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_x,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_y,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_z,
    output logic [1:0]                        o_status,
    output logic                              o_last
);
    import tafn_pkg::*;

    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int CW    = $clog2(VERTEX_DEPTH + 1);
    localparam int XW    = (CW > CORNER_W) ? CW : CORNER_W;
    localparam int VW    = 3 * COORD_W;
    localparam int NUM_W = COORD_W + NORM_FRAC;

    logic signed [COORD_W-1:0] r_off_x, r_off_y, r_off_z;
    logic [CW-1:0]             r_count;
    logic [VW-1:0]             r_mem [VERTEX_DEPTH];
    logic [VW-1:0]             r_rd;
    logic [AW-1:0]             r_addr [3];
    logic [2:0]                r_ok;
    logic signed [COORD_W-1:0] r_px [3];
    logic signed [COORD_W-1:0] r_py [3];
    logic signed [COORD_W-1:0] r_pz [3];
    logic signed [COORD_W:0]   r_d [6];
    logic signed [COORD_W-1:0] r_ds [6];
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_c [3];
    logic [63:0]               r_cm [3];
    logic [2:0]                r_cn;
    logic                      r_degen;
    logic [63:0]               r_sq;
    logic [63:0]               r_rem, r_res, r_bit;
    logic [NUM_W-1:0]          r_num, r_dvs;
    logic [DIV_STEPS-1:0]      r_q;
    logic signed [NORM_W-1:0]  r_nrm [3];
    logic signed [COORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic signed [NORM_W-1:0]  r_out_nx, r_out_ny, r_out_nz;
    t_status                   r_out_status;
    logic                      r_out_last;

    logic [CORNER_W-1:0]       corner [3];
    logic [XW-1:0]             idx_ext [3];
    logic [XW-1:0]             idx_m1 [3];
    logic [2:0]                ok_in;
    logic [COORD_W:0]          mag [6];
    logic [COORD_W:0]          mag_or;
    logic [1:0]                dsh;
    logic [COORD_W:0]          smag [6];
    logic signed [COORD_W-1:0] ds_n [6];
    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic [63:0]               cm_or;
    logic [63:0]               sq_try;
    logic [COORD_W-1:0]        len;
    logic [NORM_W-1:0]         q_ext;
    logic                      store_room;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign store_room  = (r_count < CW'(VERTEX_DEPTH));

    assign corner[0] = i_corner_a;
    assign corner[1] = i_corner_b;
    assign corner[2] = i_corner_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            idx_ext[k] = XW'(corner[k]);
            idx_m1[k]  = idx_ext[k] - 1'b1;
            ok_in[k]   = (idx_ext[k] != '0) && (idx_ext[k] <= XW'(r_count));
        end
    end

    // Shared right shift that brings every edge difference magnitude below 2^30.
    always_comb begin
        mag_or = '0;
        for (int i = 0; i < 6; i++) begin
            mag[i] = r_d[i][COORD_W] ? unsigned'(-r_d[i]) : unsigned'(r_d[i]);
            mag_or = mag_or | mag[i];
        end
        if (mag_or[COORD_W]) begin
            dsh = 2'd3;
        end else if (mag_or[COORD_W-1]) begin
            dsh = 2'd2;
        end else if (mag_or[COORD_W-2]) begin
            dsh = 2'd1;
        end else begin
            dsh = 2'd0;
        end
        for (int i = 0; i < 6; i++) begin
            smag[i] = mag[i] >> dsh;
            ds_n[i] = r_d[i][COORD_W] ? -signed'(COORD_W'(smag[i])) : signed'(COORD_W'(smag[i]));
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            M_D1D5:  begin mul_a = r_ds[1]; mul_b = r_ds[5]; end
            M_D4D2:  begin mul_a = r_ds[4]; mul_b = r_ds[2]; end
            M_D3D2:  begin mul_a = r_ds[3]; mul_b = r_ds[2]; end
            M_D0D5:  begin mul_a = r_ds[0]; mul_b = r_ds[5]; end
            M_D0D4:  begin mul_a = r_ds[0]; mul_b = r_ds[4]; end
            M_D3D1:  begin mul_a = r_ds[3]; mul_b = r_ds[1]; end
            M_SQ0:   begin mul_a = signed'({1'b0, r_cm[0][COORD_W-2:0]}); mul_b = mul_a; end
            M_SQ1:   begin mul_a = signed'({1'b0, r_cm[1][COORD_W-2:0]}); mul_b = mul_a; end
            M_SQ2:   begin mul_a = signed'({1'b0, r_cm[2][COORD_W-2:0]}); mul_b = mul_a; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign cm_or  = r_cm[0] | r_cm[1] | r_cm[2];
    assign sq_try = r_res + r_bit;
    assign len    = r_res[COORD_W-1:0];
    assign q_ext  = {1'b0, r_q};

    assign o_sts.bad       = ~&r_ok;
    assign o_sts.degen     = r_degen;
    assign o_sts.norm_done = ~|cm_or[63:31] & cm_or[30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OFFSET_X: r_off_x <= signed'(i_cfg_data);
                    CFG_OFFSET_Y: r_off_y <= signed'(i_cfg_data);
                    CFG_OFFSET_Z: r_off_z <= signed'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.wr_vtx && store_room) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vtx && store_room) begin
            r_mem[r_count[AW-1:0]] <= {sat_add(i_coord_x, r_off_x),
                                       sat_add(i_coord_y, r_off_y),
                                       sat_add(i_coord_z, r_off_z)};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_addr[i_cmd.rd_sel]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int k = 0; k < 3; k++) begin
                r_addr[k] <= idx_m1[k][AW-1:0];
                r_nrm[k]  <= '0;
            end
            r_ok    <= ok_in;
            r_degen <= 1'b0;
        end
        if (i_cmd.cap_en) begin
            if (r_ok[i_cmd.cap_sel]) begin
                r_px[i_cmd.cap_sel] <= signed'(r_rd[VW-1:2*COORD_W]);
                r_py[i_cmd.cap_sel] <= signed'(r_rd[2*COORD_W-1:COORD_W]);
                r_pz[i_cmd.cap_sel] <= signed'(r_rd[COORD_W-1:0]);
            end else begin
                r_px[i_cmd.cap_sel] <= '0;
                r_py[i_cmd.cap_sel] <= '0;
                r_pz[i_cmd.cap_sel] <= '0;
            end
        end
        if (i_cmd.diff) begin
            r_d[0] <= {r_px[0][COORD_W-1], r_px[0]} - {r_px[1][COORD_W-1], r_px[1]};
            r_d[1] <= {r_py[0][COORD_W-1], r_py[0]} - {r_py[1][COORD_W-1], r_py[1]};
            r_d[2] <= {r_pz[0][COORD_W-1], r_pz[0]} - {r_pz[1][COORD_W-1], r_pz[1]};
            r_d[3] <= {r_px[0][COORD_W-1], r_px[0]} - {r_px[2][COORD_W-1], r_px[2]};
            r_d[4] <= {r_py[0][COORD_W-1], r_py[0]} - {r_py[2][COORD_W-1], r_py[2]};
            r_d[5] <= {r_pz[0][COORD_W-1], r_pz[0]} - {r_pz[2][COORD_W-1], r_pz[2]};
        end
        if (i_cmd.shift) begin
            for (int i = 0; i < 6; i++) begin
                r_ds[i] <= ds_n[i];
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_sel)
                M_D1D5:  r_c[0] <= r_prod;
                M_D4D2:  r_c[0] <= r_c[0] - r_prod;
                M_D3D2:  r_c[1] <= r_prod;
                M_D0D5:  r_c[1] <= r_c[1] - r_prod;
                M_D0D4:  r_c[2] <= r_prod;
                M_D3D1:  r_c[2] <= r_c[2] - r_prod;
                M_SQ0:   r_sq   <= unsigned'(r_prod);
                M_SQ1:   r_sq   <= r_sq + unsigned'(r_prod);
                M_SQ2:   r_sq   <= r_sq + unsigned'(r_prod);
                default: ;
            endcase
        end
        if (i_cmd.cmag) begin
            for (int i = 0; i < 3; i++) begin
                r_cm[i] <= r_c[i][63] ? unsigned'(-r_c[i]) : unsigned'(r_c[i]);
                r_cn[i] <= r_c[i][63];
            end
            r_degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        end
        // One bit of normalizing shift per cycle until the largest lands in [2^30, 2^31).
        if (i_cmd.nrm_step) begin
            for (int i = 0; i < 3; i++) begin
                r_cm[i] <= (|cm_or[63:31]) ? (r_cm[i] >> 1) : (r_cm[i] << 1);
            end
        end
        if (i_cmd.sqrt_init) begin
            r_rem <= r_sq;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= sq_try) begin
                r_rem <= r_rem - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_num <= NUM_W'({r_cm[i_cmd.comp][COORD_W-2:0], {NORM_FRAC{1'b0}}})
                     + NUM_W'(len >> 1);
            r_dvs <= {len, {NORM_FRAC{1'b0}}};
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_num >= r_dvs) begin
                r_num <= r_num - r_dvs;
                r_q   <= {r_q[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[DIV_STEPS-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
        if (i_cmd.div_store) begin
            r_nrm[i_cmd.comp] <= r_cn[i_cmd.comp] ? -signed'(q_ext) : signed'(q_ext);
        end
        if (i_cmd.out_load) begin
            r_out_x    <= r_px[i_cmd.out_sel];
            r_out_y    <= r_py[i_cmd.out_sel];
            r_out_z    <= r_pz[i_cmd.out_sel];
            r_out_nx   <= r_nrm[0];
            r_out_ny   <= r_nrm[1];
            r_out_nz   <= r_nrm[2];
            r_out_last <= (i_cmd.out_sel == 2'd2);
            if (~&r_ok) begin
                r_out_status <= ST_BAD_INDEX;
            end else if (r_degen) begin
                r_out_status <= ST_DEGENERATE;
            end else begin
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_pos_x  = r_out_x;
    assign o_pos_y  = r_out_y;
    assign o_pos_z  = r_out_z;
    assign o_norm_x = r_out_nx;
    assign o_norm_y = r_out_ny;
    assign o_norm_z = r_out_nz;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule

@@ sv/triangle_assembly_face_normal.sv @@
// Top level of the indexed triangle assembler with flat Q2.14 face normals.
//
// A vertex record (func 0) is taken in any state: the configured offset is
// added with saturation and the point is written to the vertex store at the
// next free entry, or dropped when the store is full. A face record (func 1)
// is taken only when the sequencer is idle and then occupies the single
// shared datapath: three store reads, the edge differences and their common
// shift, six products through one 32x32 multiplier, magnitude and a
// normalizing shift of up to 30 bits, three squares, a bit-per-cycle square
// root and three restoring divisions, followed by the three result
// transfers. A face with a bad index finishes after the reads and a
// degenerate face after the cross product. Output stalls lengthen a face.
// The last result of a face may still wait in the output register while
// the next records are taken. The configuration port is always ready;
// registers are offset x, y and z at indices 0 to 2, and writes to other
// indices are ignored. The vertex store has no reset and no clearing pass,
// since only entries below the fill count are ever used.
module triangle_assembly_face_normal #(
    parameter int VERTEX_DEPTH = tafn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [tafn_pkg::COORD_W-1:0] i_coord_z,
    input  logic [tafn_pkg::CORNER_W-1:0]       i_corner_a,
    input  logic [tafn_pkg::CORNER_W-1:0]       i_corner_b,
    input  logic [tafn_pkg::CORNER_W-1:0]       i_corner_c,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [tafn_pkg::COORD_W-1:0] o_pos_z,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_x,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_y,
    output logic signed [tafn_pkg::NORM_W-1:0]  o_norm_z,
    output logic [1:0]                          o_status,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tafn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tafn_pkg::COORD_W-1:0]        i_cfg_data
);
    import tafn_pkg::*;

    // Commands from the sequencer and the status it steers by.
    t_cmd cmd;
    t_sts sts;

    tafn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // The datapath holds the store, the offsets and all arithmetic.
    tafn_dp #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_corner_a  (i_corner_a),
        .i_corner_b  (i_corner_b),
        .i_corner_c  (i_corner_c),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_norm_x    (o_norm_x),
        .o_norm_y    (o_norm_y),
        .o_norm_z    (o_norm_z),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

@@ sv/tafn_check.sv @@
// Port-level checker for the triangle assembler and its bind to the top level.
module tafn_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                i_func,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [tafn_pkg::COORD_W-1:0] o_pos_x,
    input logic signed [tafn_pkg::NORM_W-1:0]  o_norm_x,
    input logic signed [tafn_pkg::NORM_W-1:0]  o_norm_y,
    input logic signed [tafn_pkg::NORM_W-1:0]  o_norm_z,
    input logic [1:0]                          o_status
);
    import tafn_pkg::*;

    // A result held back by the receiver stays valid with its x position and x normal unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_norm_x))
        else $error("stalled result changed");

    // Any failed face carries a zero normal.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_norm_x == '0) && (o_norm_y == '0)
            && (o_norm_z == '0))
        else $error("nonzero normal on failed face");

    // A unit normal in Q2.14 never exceeds one in any component.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_x <= 16'sd16384) && (o_norm_x >= -16'sd16384)
            && (o_norm_y <= 16'sd16384) && (o_norm_y >= -16'sd16384)
            && (o_norm_z <= 16'sd16384) && (o_norm_z >= -16'sd16384))
        else $error("normal component out of range");

    // Right after a face transfer the block is busy and holds off another face.
    a_face_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_func |=> !i_func || o_stall)
        else $error("face accepted while busy");

endmodule

bind triangle_assembly_face_normal tafn_check u_check (.*);
